@@ src/cqf_pkg.sv @@
// Shared types and codes for the circular queue FIFO.
// No dependencies; imported by every module of the block but cqf_ram.
package cqf_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_TRAV = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_TRAV = 2'd2
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_if_t;

endpackage

@@ src/cqf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cqf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/cqf_front.sv @@
// Front end: accepts transactions, classifies them, and queues commands.
// Depends on cqf_pkg.
module cqf_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       kind,
  input  logic signed [cqf_pkg::WORD_W-1:0] value,
  output cqf_pkg::cmd_if_t                 cmd_out,
  input  logic                             cmd_pop
);
  import cqf_pkg::*;

  localparam int unsigned QD = 2;

  cmd_t             q [QD];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;
  logic             accept;
  logic             enq;
  logic             deq;
  cmd_t             cmd_in;

  assign full   = (cnt == 2'(QD));
  assign accept = push && !full;

  always_comb begin
    cmd_in.value = value;
    cmd_in.op    = OP_ENQ;
    enq          = 1'b0;
    case (kind_t'(kind))
      KIND_ENQ: begin
        cmd_in.op = OP_ENQ;
        enq       = accept;
      end
      KIND_DEQ: begin
        cmd_in.op = OP_DEQ;
        enq       = accept;
      end
      KIND_TRAV: begin
        cmd_in.op = OP_TRAV;
        enq       = accept;
      end
      default: begin
        enq = 1'b0;
      end
    endcase
  end

  assign deq           = cmd_pop && (cnt != 2'd0);
  assign cmd_out.valid = (cnt != 2'd0);
  assign cmd_out.cmd   = q[rp];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp] <= cmd_in;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (enq) begin
        wp <= ~wp;
      end
      if (deq) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(enq) - 2'(deq);
    end
  end

endmodule

@@ src/cqf_back.sv @@
// Back end: owns head/tail and the slot RAM, executes commands, drives results.
// Depends on cqf_pkg and cqf_ram.
module cqf_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cqf_pkg::cmd_if_t                  cmd_in,
  output logic                              cmd_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        status,
  output logic signed [cqf_pkg::WORD_W-1:0] data,
  output logic                              last
);
  import cqf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [AW-1:0]     head;
  logic [AW-1:0]     head_next;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     tail_next;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     idx_next;
  logic              trav_on;
  logic              trav_on_next;
  logic [AW-1:0]     cur;
  logic              q_empty;
  logic              q_full;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;

  logic              issue;
  status_t           iss_status;
  logic              iss_last;
  logic              iss_ram;

  logic              s1_valid;
  status_t           s1_status;
  logic              s1_last;
  logic              s1_ram;
  logic              s1_go;
  logic              out_load;
  logic [WORD_W-1:0] s1_data;

  logic              out_valid;

  cqf_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (cmd_in.cmd.value),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign q_empty  = (head == tail);
  assign q_full   = (nxt(tail) == head);
  assign cur      = trav_on ? idx : head;
  assign out_load = s1_valid && (!out_valid || pop);
  assign s1_go    = !s1_valid || out_load;

  always_comb begin
    issue        = 1'b0;
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    raddr        = cur;
    iss_status   = ST_OK;
    iss_last     = 1'b1;
    iss_ram      = 1'b0;
    head_next    = head;
    tail_next    = tail;
    idx_next     = idx;
    trav_on_next = trav_on;
    if (cmd_in.valid && s1_go) begin
      issue = 1'b1;
      case (cmd_in.cmd.op)
        OP_ENQ: begin
          cmd_pop = 1'b1;
          if (q_full) begin
            iss_status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            tail_next = nxt(tail);
          end
        end
        OP_DEQ: begin
          cmd_pop = 1'b1;
          if (q_empty) begin
            iss_status = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            iss_ram   = 1'b1;
            head_next = nxt(head);
          end
        end
        OP_TRAV: begin
          if (q_empty) begin
            cmd_pop    = 1'b1;
            iss_status = ST_EMPTY;
          end else begin
            ram_re   = 1'b1;
            iss_ram  = 1'b1;
            iss_last = (nxt(cur) == tail);
            if (iss_last) begin
              cmd_pop      = 1'b1;
              trav_on_next = 1'b0;
            end else begin
              trav_on_next = 1'b1;
              idx_next     = nxt(cur);
            end
          end
        end
        default: begin
          cmd_pop = 1'b1;
          issue   = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (s1_ram) begin
      s1_data = rdata;
    end else if (s1_status == ST_EMPTY) begin
      s1_data = '1;
    end else begin
      s1_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_status <= iss_status;
      s1_last   <= iss_last;
      s1_ram    <= iss_ram;
    end
    if (out_load) begin
      status <= s1_status;
      data   <= s1_data;
      last   <= s1_last;
    end
    idx <= idx_next;
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      trav_on   <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      trav_on <= trav_on_next;
      if (s1_go) begin
        s1_valid <= issue;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

endmodule

@@ src/circular_queue_fifo_core.sv @@
// A result passes from the command queue through the issue stage s1 into the output register.
// Throughput while pop keeps up: one transaction per cycle for enqueue and dequeue;
// a traverse of n held words gives n results, one per cycle (single RAM read port).
// Reset (rst, synchronous) empties the queue and all pipeline stages; no clearing pass.
// Top level: front end, command queue and back end. Depends on cqf_pkg, cqf_front,
// cqf_back.
module circular_queue_fifo_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        kind,
  input  logic signed [cqf_pkg::WORD_W-1:0] value,
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        status,
  output logic signed [cqf_pkg::WORD_W-1:0] data,
  output logic                              last
);
  import cqf_pkg::*;

  cmd_if_t cmd;
  logic    cmd_pop;

  cqf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .kind    (kind),
    .value   (value),
    .cmd_out (cmd),
    .cmd_pop (cmd_pop)
  );

  cqf_back #(.DEPTH(DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd),
    .cmd_pop (cmd_pop),
    .empty   (empty),
    .pop     (pop),
    .status  (status),
    .data    (data),
    .last    (last)
  );

endmodule

@@ src/cqf_checker.sv @@
// Port-level checks for circular_queue_fifo_core, bound to the top level.
// Depends on cqf_pkg.
module cqf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              empty,
  input logic                              pop,
  input logic [1:0]                        status,
  input logic signed [cqf_pkg::WORD_W-1:0] data,
  input logic                              last
);
  import cqf_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(data) && $stable(status) && $stable(last)))
    else $error("waiting result changed");

  a_full_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_FULL) |-> (data == 0 && last))
    else $error("full status with bad data or last");

  a_empty_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_EMPTY) |-> (data == -1 && last))
    else $error("empty status with bad data or last");

endmodule

bind circular_queue_fifo_core cqf_checker u_cqf_checker (.*);
